/* rtl/mscg_pkg.sv */
// ============================================================================
// mscg_pkg: shared definitions for the color gradient unit
// Register indexes, field widths and the byte lane masks of an 0xRRGGBB word.
// ============================================================================
package mscg_pkg;

    localparam int COLOR_W = 24;
    localparam int COUNT_W = 3;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd2;
    localparam logic [COUNT_W-1:0] COUNT_MIN   = 3'd2;

    // Register indexes of the configuration port.
    localparam int REG_STOP_COUNT   = 0;
    localparam int REG_STOP_COLOR_0 = 1;

    localparam int NUM_LANES = 3;

    localparam logic [COLOR_W-1:0] LANE_MASK [NUM_LANES] = '{
        24'hFF0000,
        24'h00FF00,
        24'h0000FF
    };

endpackage

/* rtl/mscg_ram.sv */
// ============================================================================
// mscg_ram: generic RAM with one write port and two registered read ports
// The read data of both ports is registered and follows the address in the next cycle.
// ============================================================================
module mscg_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 6
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

/* rtl/mscg_front.sv */
// ============================================================================
// mscg_front: position intake and segment classification
// Clamps the position, scales it by the segment count and splits it into a
// segment number and a blend fraction that go to the queue.
// ============================================================================
module mscg_front #(
    parameter int MAX_STOPS = 6,
    parameter int FRAC_BITS = 16
) (
    input  logic                                     i_start,
    input  logic signed [FRAC_BITS+1:0]              i_position,
    input  logic [mscg_pkg::COUNT_W-1:0]             i_stop_count,
    input  logic                                     i_queue_full,
    output logic                                     o_busy,
    output logic                                     o_push,
    output logic [$clog2(MAX_STOPS)+FRAC_BITS-1:0]   o_entry
);

    localparam int AW = $clog2(MAX_STOPS);
    localparam int SW = FRAC_BITS + 3;

    logic [mscg_pkg::COUNT_W-1:0] count_c;
    logic [mscg_pkg::COUNT_W-1:0] count_m1;
    logic [mscg_pkg::COUNT_W-1:0] count_m2;
    logic [FRAC_BITS-1:0]         pos_c;
    logic [SW-1:0]                scaled;
    logic [2:0]                   seg_raw;
    logic [2:0]                   seg_c;

    always_comb begin
        // Out of range stop counts fall back to the nearest legal count.
        if (i_stop_count < mscg_pkg::COUNT_MIN) begin
            count_c = mscg_pkg::COUNT_MIN;
        end else if (i_stop_count > mscg_pkg::COUNT_W'(MAX_STOPS)) begin
            count_c = mscg_pkg::COUNT_W'(MAX_STOPS);
        end else begin
            count_c = i_stop_count;
        end
        count_m1 = count_c - 3'd1;
        count_m2 = count_c - 3'd2;

        // Negative positions go to zero, positions of one or more to just below one.
        if (i_position[FRAC_BITS+1]) begin
            pos_c = '0;
        end else if (i_position[FRAC_BITS]) begin
            pos_c = '1;
        end else begin
            pos_c = i_position[FRAC_BITS-1:0];
        end

        scaled  = SW'(pos_c) * SW'(count_m1);
        seg_raw = scaled[SW-1:FRAC_BITS];
        seg_c   = (seg_raw > count_m2) ? count_m2 : seg_raw;
    end

    assign o_busy  = i_queue_full;
    assign o_push  = i_start && !i_queue_full;
    assign o_entry = {seg_c[AW-1:0], scaled[FRAC_BITS-1:0]};

endmodule

/* rtl/mscg_queue.sv */
// ============================================================================
// mscg_queue: two-entry queue between intake and blend pipeline
// Push and pop may happen in the same cycle.
// ============================================================================
module mscg_queue #(
    parameter int WIDTH = 19
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_count;
    logic [1:0]       n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_comb begin
        n_count = r_count + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wptr <= ~r_wptr;
            end
            if (do_pop) begin
                r_rptr <= ~r_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

/* rtl/mscg_back.sv */
// ============================================================================
// mscg_back: stop lookup and per-lane blend pipeline
// Reads the two stops of a segment, multiplies each lane difference by the
// fraction, then truncates toward zero, adds and merges the lanes.
// ============================================================================
module mscg_back #(
    parameter int MAX_STOPS = 6,
    parameter int FRAC_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_head_valid,
    input  logic [$clog2(MAX_STOPS)+FRAC_BITS-1:0] i_head,
    output logic                                   o_pop,
    input  logic                                   i_we,
    input  logic [$clog2(MAX_STOPS)-1:0]           i_waddr,
    input  logic [mscg_pkg::COLOR_W-1:0]           i_wdata,
    input  logic [MAX_STOPS-1:0]                   i_stop_valid,
    output logic                                   o_done,
    output logic [mscg_pkg::COLOR_W-1:0]           o_color
);

    localparam int AW = $clog2(MAX_STOPS);
    localparam int CW = mscg_pkg::COLOR_W;
    localparam int NL = mscg_pkg::NUM_LANES;
    localparam int PW = CW + FRAC_BITS + 2;

    logic [AW-1:0]        seg_a;
    logic [AW-1:0]        seg_b;
    logic [CW-1:0]        rd_a;
    logic [CW-1:0]        rd_b;
    logic [CW-1:0]        col_a;
    logic [CW-1:0]        col_b;

    logic                 r_s1_valid;
    logic [FRAC_BITS-1:0] r_s1_t;
    logic                 r_s1_va;
    logic                 r_s1_vb;

    logic                 r_s2_valid;
    logic [CW-1:0]        r_s2_start;
    logic signed [PW-1:0] r_s2_prod [NL];
    logic signed [PW-1:0] n_s2_prod [NL];

    logic                 r_done;
    logic [CW-1:0]        r_color;
    logic [CW-1:0]        n_color;

    assign o_pop = i_head_valid;
    assign seg_a = i_head[AW+FRAC_BITS-1:FRAC_BITS];
    assign seg_b = seg_a + AW'(1);

    mscg_ram #(
        .WIDTH (CW),
        .DEPTH (MAX_STOPS)
    ) u_stops (
        .i_clk     (i_clk),
        .i_we      (i_we),
        .i_waddr   (i_waddr),
        .i_wdata   (i_wdata),
        .i_raddr_a (seg_a),
        .i_raddr_b (seg_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    // A stop that was never written reads as black.
    assign col_a = r_s1_va ? rd_a : '0;
    assign col_b = r_s1_vb ? rd_b : '0;

    always_comb begin
        logic signed [CW:0]   diff;
        logic signed [PW-1:0] diff_x;
        logic signed [PW-1:0] t_x;
        for (int l = 0; l < NL; l++) begin
            diff = signed'({1'b0, col_b & mscg_pkg::LANE_MASK[l]})
                 - signed'({1'b0, col_a & mscg_pkg::LANE_MASK[l]});
            diff_x = PW'(diff);
            t_x    = PW'(signed'({1'b0, r_s1_t}));
            n_s2_prod[l] = diff_x * t_x;
        end
    end

    always_comb begin
        logic signed [PW-1:0] q_full;
        logic signed [CW:0]   q;
        logic signed [CW+1:0] sum;
        n_color = '0;
        for (int l = 0; l < NL; l++) begin
            q_full = r_s2_prod[l] >>> FRAC_BITS;
            q      = q_full[CW:0];
            // Arithmetic shift floors; negative products with a remainder move up by one.
            if (r_s2_prod[l][PW-1] && (|r_s2_prod[l][FRAC_BITS-1:0])) begin
                q = q + (CW+1)'(1);
            end
            sum = signed'({2'b00, r_s2_start & mscg_pkg::LANE_MASK[l]}) + (CW+2)'(q);
            n_color = n_color | (sum[CW-1:0] & mscg_pkg::LANE_MASK[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_s1_valid <= i_head_valid;
            r_s2_valid <= r_s1_valid;
            r_done     <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_t     <= i_head[FRAC_BITS-1:0];
        r_s1_va    <= i_stop_valid[seg_a];
        r_s1_vb    <= i_stop_valid[seg_b];
        r_s2_start <= col_a;
        r_s2_prod  <= n_s2_prod;
        r_color    <= n_color;
    end

    assign o_done  = r_done;
    assign o_color = r_color;

endmodule

/* rtl/multi_stop_color_gradient_unit.sv */
// ============================================================================
// multi_stop_color_gradient_unit: multi-stop RGB gradient lookup
// Maps a signed fixed-point position onto a color blended between evenly
// spaced color stops.
// ============================================================================
// Usage:
//   A position is accepted at a rising edge where i_start is high and o_busy
//   is low. The block takes one position every cycle; o_busy only rises if
//   the two-entry queue between intake and blend pipeline were full, which
//   does not happen since the pipeline drains it every cycle.
//   The color of an item is shown on o_color for exactly one cycle, flagged
//   by o_done. The item waits in the queue while the stop memory is read;
//   the read data, the lane products and the result of truncation, add and
//   lane merge are registered in that order. Results come out in order.
//   The receiver cannot stall, so the pipeline never holds an item back.
//   Configuration arrives on its own valid/ready channel; o_cfg_ready is
//   always high. Index 0 sets the stop count, indexes 1 to MAX_STOPS set the
//   stop colors; other indexes are ignored. Write it only while no item is in
//   flight.
//   Reset sets the stop count to two and marks all stops unwritten, so every
//   stop reads as black until it is written. The pipeline is empty after
//   reset.
// ============================================================================
module multi_stop_color_gradient_unit #(
    parameter int MAX_STOPS = 6,
    parameter int FRAC_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    output logic                                 o_busy,
    input  logic signed [FRAC_BITS+1:0]          i_position,
    output logic                                 o_done,
    output logic [mscg_pkg::COLOR_W-1:0]         o_color,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [$clog2(MAX_STOPS+1)-1:0]       i_cfg_index,
    input  logic [mscg_pkg::COLOR_W-1:0]         i_cfg_data
);

    localparam int AW = $clog2(MAX_STOPS);
    localparam int IW = $clog2(MAX_STOPS + 1);
    localparam int QW = AW + FRAC_BITS;

    // Configuration state: stop count and one valid bit per stop color.
    logic [mscg_pkg::COUNT_W-1:0] r_stop_count;
    logic [MAX_STOPS-1:0]         r_stop_valid;

    logic          cfg_wr;
    logic          color_wr;
    logic [IW-1:0] color_idx;
    logic [AW-1:0] color_addr;

    // Queue between intake and blend pipeline.
    logic          push;
    logic          pop;
    logic [QW-1:0] entry;
    logic [QW-1:0] head;
    logic          q_full;
    logic          q_empty;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    // Color registers live at indexes just past the stop count register.
    assign color_wr   = cfg_wr
                     && (i_cfg_index >= IW'(mscg_pkg::REG_STOP_COLOR_0))
                     && (i_cfg_index <= IW'(MAX_STOPS));
    assign color_idx  = i_cfg_index - IW'(mscg_pkg::REG_STOP_COLOR_0);
    assign color_addr = color_idx[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_count <= mscg_pkg::COUNT_RESET;
            r_stop_valid <= '0;
        end else begin
            if (cfg_wr && (i_cfg_index == IW'(mscg_pkg::REG_STOP_COUNT))) begin
                r_stop_count <= i_cfg_data[mscg_pkg::COUNT_W-1:0];
            end
            if (color_wr) begin
                r_stop_valid[color_addr] <= 1'b1;
            end
        end
    end

    mscg_front #(
        .MAX_STOPS (MAX_STOPS),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_start      (i_start),
        .i_position   (i_position),
        .i_stop_count (r_stop_count),
        .i_queue_full (q_full),
        .o_busy       (o_busy),
        .o_push       (push),
        .o_entry      (entry)
    );

    mscg_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (entry),
        .i_pop   (pop),
        .o_data  (head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    mscg_back #(
        .MAX_STOPS (MAX_STOPS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (!q_empty),
        .i_head       (head),
        .o_pop        (pop),
        .i_we         (color_wr),
        .i_waddr      (color_addr),
        .i_wdata      (i_cfg_data),
        .i_stop_valid (r_stop_valid),
        .o_done       (o_done),
        .o_color      (o_color)
    );

endmodule
